FILE: hdl/timestamp_fraction_offset_formatter_unit_assert.svh
// Assertion macros for the timestamp tail formatter.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef TIMESTAMP_FRACTION_OFFSET_FORMATTER_UNIT_ASSERT_SVH
`define TIMESTAMP_FRACTION_OFFSET_FORMATTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TSFO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TSFO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSFO_ASSERT_IMP(lbl, ante, cons, msg)
`define TSFO_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/tsfo_pkg.sv
// Types, constants and helpers for the timestamp tail formatter.
// No dependencies; imported by the top level.
package tsfo_pkg;

  localparam int NANOS_W  = 30;
  localparam int OFFSET_W = 18;
  localparam int PREC_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CHAR_W   = 8;
  localparam int CNT_W    = 5;
  localparam int MAX_CHARS_N = 16;

  localparam logic [CNT_W-1:0]   MAX_CHARS = CNT_W'(MAX_CHARS_N);
  localparam logic [NANOS_W-1:0] NANOS_MAX = 30'd999999999;

  // Reciprocals for the constant divisions, each checked to give the exact
  // floor over the full range of its operand.
  localparam logic [30:0] RECIP_1000_WIDE = 31'd1099511628; // 2^40 / 1000
  localparam logic [20:0] RECIP_1000_NARR = 21'd1073742;    // 2^30 / 1000
  localparam logic [18:0] RECIP_3600      = 19'd298262;     // 2^30 / 3600
  localparam logic [14:0] RECIP_60        = 15'd17477;      // 2^20 / 60
  localparam logic [12:0] RECIP_100       = 13'd5243;       // 2^19 / 100
  localparam logic [7:0]  RECIP_10        = 8'd205;         // 2^11 / 10

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED     = 2'd1;

  localparam logic [PREC_W-1:0] PREC_NONE  = 4'd0;
  localparam logic [PREC_W-1:0] PREC_MILLI = 4'd3;
  localparam logic [PREC_W-1:0] PREC_MICRO = 4'd6;
  localparam logic [PREC_W-1:0] PREC_NANO  = 4'd9;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ZULU  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    FRAC_NONE,
    FRAC_MILLI,
    FRAC_MICRO,
    FRAC_NANO
  } frac_len_e;

  typedef enum logic [1:0] {
    OFF_NONE,
    OFF_ZULU,
    OFF_FULL
  } off_kind_e;

  function automatic logic [CHAR_W-1:0] dig_char(logic [3:0] d);
    return CH_ZERO | {4'h0, d};
  endfunction

endpackage

FILE: hdl/timestamp_fraction_offset_formatter_unit.sv
// Top level of the timestamp tail formatter: arithmetic pipeline and output
// serialiser. Depends on tsfo_pkg and timestamp_fraction_offset_formatter_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries nanos_i, offset_seconds_i
//   and has_offset_i. Output channel (out_valid_o / out_stall_i) carries one
//   ASCII character per transaction on out_char_o, with last_char_o marking the
//   final character of an item. An item that yields no characters produces no
//   output transaction at all.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes precision
//   (index 0) and fixed-width mode (index 1); it is always ready and must only
//   be used while the block is idle.
//   An accepted item passes seven pipeline stages and the output register
//   before its first character is presented. Throughput: one character per
//   cycle while out_stall_i is low. An item of n characters (at most 16)
//   holds the output shift register until all n are taken, which sets the
//   sustained rate; up to seven further items queue in the pipeline meanwhile.
//   When the receiver stalls, the current character holds and the pipeline
//   fills, after which in_stall_o rises. Reset empties the pipeline, sets
//   precision to nine digits and selects trimmed mode.
module timestamp_fraction_offset_formatter_unit
  import tsfo_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [NANOS_W-1:0]          nanos_i,
  input  logic signed [OFFSET_W-1:0]  offset_seconds_i,
  input  logic                        has_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [CHAR_W-1:0]           out_char_o,
  output logic                        last_char_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [PREC_W-1:0]           cfg_data_i
);

`include "timestamp_fraction_offset_formatter_unit_assert.svh"

  localparam int NSTAGE = 7;

  // Configuration registers.
  logic [PREC_W-1:0] prec_q;
  logic              fixed_q;

  // Pipeline control.
  logic [NSTAGE:1] s_valid_q, s_valid_d;
  logic [NSTAGE:1] stage_en;

  // Stage 1: saturated nanos, offset magnitude.
  logic [NANOS_W-1:0]  s1_ns_q, s1_ns_d;
  logic [OFFSET_W-1:0] s1_mag_q, s1_mag_d;
  logic                s1_neg_q;
  off_kind_e           s1_kind_q, s1_kind_d;

  // Stage 2: reciprocal products.
  logic [NANOS_W-1:0]  s2_ns_q;
  logic [OFFSET_W-1:0] s2_mag_q;
  logic                s2_neg_q;
  off_kind_e           s2_kind_q;
  logic [60:0]         s2_p1_q, s2_p1_d;
  logic [36:0]         s2_hp_q, s2_hp_d;

  // Stage 3: microsecond count, nanosecond group, hours, leftover seconds.
  logic [19:0]         s3_q1_q, s3_q1_d;
  logic [9:0]          s3_nn_q, s3_nn_d;
  logic [5:0]          s3_hours_q, s3_hours_d;
  logic [11:0]         s3_rem_q, s3_rem_d;
  logic                s3_neg_q;
  off_kind_e           s3_kind_q;
  logic [29:0]         s3_nn_full;
  logic [17:0]         s3_rem_full;

  // Stage 4: second-level reciprocal products.
  logic [19:0]         s4_q1_q;
  logic [9:0]          s4_nn_q;
  logic [5:0]          s4_hours_q;
  logic                s4_neg_q;
  off_kind_e           s4_kind_q;
  logic [40:0]         s4_msp_q, s4_msp_d;
  logic [26:0]         s4_minp_q, s4_minp_d;

  // Stage 5: the three groups, minutes and fraction length.
  logic [9:0]          s5_grp_q [3];
  logic [9:0]          s5_grp_d [3];
  logic [5:0]          s5_hours_q;
  logic [5:0]          s5_min_q, s5_min_d;
  logic                s5_neg_q;
  off_kind_e           s5_kind_q;
  frac_len_e           s5_frac_q, s5_frac_d;
  logic [19:0]         s5_us_full;
  logic                s5_any;

  // Stage 6: hundreds digits and offset digits.
  logic [3:0]          s6_hund_q [3];
  logic [3:0]          s6_hund_d [3];
  logic [6:0]          s6_r_q [3];
  logic [6:0]          s6_r_d [3];
  logic [3:0]          s6_ht_q, s6_ht_d, s6_hu_q, s6_hu_d;
  logic [3:0]          s6_mt_q, s6_mt_d, s6_mu_q, s6_mu_d;
  logic                s6_neg_q;
  off_kind_e           s6_kind_q;
  frac_len_e           s6_frac_q;
  logic [22:0]         s6_hprod [3];
  logic [9:0]          s6_rfull [3];
  logic [14:0]         s6_htp, s6_mtp;
  logic [5:0]          s6_hu_full, s6_mu_full;

  // Stage 7: assembled characters.
  logic [CHAR_W-1:0]   s7_chars_q [MAX_CHARS_N];
  logic [CHAR_W-1:0]   s7_chars_d [MAX_CHARS_N];
  logic [CNT_W-1:0]    s7_cnt_q, s7_cnt_d;
  logic [3:0]          s7_tens [3];
  logic [3:0]          s7_units [3];
  logic [14:0]         s7_tprod [3];
  logic [6:0]          s7_ufull [3];
  logic [CHAR_W-1:0]   frac_chars [MAX_CHARS_N];
  logic [CHAR_W-1:0]   off_chars [8];
  logic [CNT_W-1:0]    frac_n, off_n;
  logic [CNT_W-1:0]    rel_idx;

  // Output shift register.
  logic [CHAR_W-1:0]   buf_q [MAX_CHARS_N];
  logic [CHAR_W-1:0]   buf_d [MAX_CHARS_N];
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  logic                out_acc, ser_free, ser_load;

  // ---------------------------------------------------------------------------
  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q  <= PREC_NANO;
      fixed_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PRECISION: prec_q  <= cfg_data_i;
        REG_FIXED:     fixed_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its content moves on.
  assign out_acc  = out_valid_q && !out_stall_i;
  assign ser_free = !out_valid_q || (!out_stall_i && (rem_q == CNT_W'(1)));
  assign ser_load = ser_free && s_valid_q[NSTAGE] && (s7_cnt_q != '0);

  always_comb begin
    stage_en[NSTAGE] = !s_valid_q[NSTAGE] || ser_free || (s7_cnt_q == '0);
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      stage_en[k] = !s_valid_q[k] || stage_en[k+1];
    end
    s_valid_d[1] = stage_en[1] ? in_valid_i : s_valid_q[1];
    for (int k = 2; k <= NSTAGE; k++) begin
      s_valid_d[k] = stage_en[k] ? s_valid_q[k-1] : s_valid_q[k];
    end
  end

  assign in_stall_o = !stage_en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= '0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath, combinational part of each stage.
  always_comb begin
    s1_ns_d  = (nanos_i > NANOS_MAX) ? NANOS_MAX : nanos_i;
    s1_mag_d = offset_seconds_i[OFFSET_W-1] ? (~offset_seconds_i + 18'sd1)
                                            : offset_seconds_i;
    if (!has_offset_i) begin
      s1_kind_d = OFF_NONE;
    end else if (offset_seconds_i == '0) begin
      s1_kind_d = OFF_ZULU;
    end else begin
      s1_kind_d = OFF_FULL;
    end
  end

  assign s2_p1_d = 61'(s1_ns_q) * 61'(RECIP_1000_WIDE);
  assign s2_hp_d = 37'(s1_mag_q) * 37'(RECIP_3600);

  always_comb begin
    s3_q1_d     = s2_p1_q[59:40];
    s3_nn_full  = s2_ns_q - (30'(s3_q1_d) * 30'd1000);
    s3_nn_d     = s3_nn_full[9:0];
    s3_hours_d  = s2_hp_q[35:30];
    s3_rem_full = s2_mag_q - (18'(s3_hours_d) * 18'd3600);
    s3_rem_d    = s3_rem_full[11:0];
  end

  assign s4_msp_d  = 41'(s3_q1_q) * 41'(RECIP_1000_NARR);
  assign s4_minp_d = 27'(s3_rem_q) * 27'(RECIP_60);

  always_comb begin
    s5_grp_d[0] = s4_msp_q[39:30];
    s5_us_full  = s4_q1_q - (20'(s5_grp_d[0]) * 20'd1000);
    s5_grp_d[1] = s5_us_full[9:0];
    s5_grp_d[2] = s4_nn_q;
    s5_min_d    = s4_minp_q[25:20];
    s5_any      = (s5_grp_d[0] != '0) || (s5_grp_d[1] != '0) || (s5_grp_d[2] != '0);

    if ((prec_q == PREC_NONE) || !(s5_any || fixed_q)) begin
      s5_frac_d = FRAC_NONE;
    end else if (fixed_q) begin
      case (prec_q)
        PREC_MILLI: s5_frac_d = FRAC_MILLI;
        PREC_MICRO: s5_frac_d = FRAC_MICRO;
        default:    s5_frac_d = FRAC_NANO;
      endcase
    end else if ((s5_grp_d[2] != '0) && (prec_q == PREC_NANO)) begin
      s5_frac_d = FRAC_NANO;
    end else if ((s5_grp_d[1] != '0) && (prec_q >= PREC_MICRO)) begin
      s5_frac_d = FRAC_MICRO;
    end else if ((s5_grp_d[0] != '0) && (prec_q >= PREC_MILLI)) begin
      s5_frac_d = FRAC_MILLI;
    end else begin
      s5_frac_d = FRAC_NONE;
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      s6_hprod[g] = 23'(s5_grp_q[g]) * 23'(RECIP_100);
      s6_hund_d[g] = s6_hprod[g][22:19];
      s6_rfull[g] = s5_grp_q[g] - (10'(s6_hund_d[g]) * 10'd100);
      s6_r_d[g]   = s6_rfull[g][6:0];
    end
    s6_htp     = 15'(s5_hours_q) * 15'(RECIP_10);
    s6_ht_d    = s6_htp[14:11];
    s6_hu_full = s5_hours_q - (6'(s6_ht_d) * 6'd10);
    s6_hu_d    = s6_hu_full[3:0];
    s6_mtp     = 15'(s5_min_q) * 15'(RECIP_10);
    s6_mt_d    = s6_mtp[14:11];
    s6_mu_full = s5_min_q - (6'(s6_mt_d) * 6'd10);
    s6_mu_d    = s6_mu_full[3:0];
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      s7_tprod[g] = 15'(s6_r_q[g]) * 15'(RECIP_10);
      s7_tens[g]  = s7_tprod[g][14:11];
      s7_ufull[g] = s6_r_q[g] - (7'(s7_tens[g]) * 7'd10);
      s7_units[g] = s7_ufull[g][3:0];
    end

    for (int i = 0; i < MAX_CHARS_N; i++) begin
      frac_chars[i] = CH_NUL;
    end
    frac_chars[0] = CH_DOT;
    for (int g = 0; g < 3; g++) begin
      frac_chars[1 + 3*g] = dig_char(s6_hund_q[g]);
      frac_chars[2 + 3*g] = dig_char(s7_tens[g]);
      frac_chars[3 + 3*g] = dig_char(s7_units[g]);
    end

    off_chars[0] = (s6_kind_q == OFF_ZULU) ? CH_ZULU : (s6_neg_q ? CH_MINUS : CH_PLUS);
    off_chars[1] = dig_char(s6_ht_q);
    off_chars[2] = dig_char(s6_hu_q);
    off_chars[3] = CH_COLON;
    off_chars[4] = dig_char(s6_mt_q);
    off_chars[5] = dig_char(s6_mu_q);
    off_chars[6] = CH_NUL;
    off_chars[7] = CH_NUL;

    case (s6_frac_q)
      FRAC_MILLI: frac_n = CNT_W'(4);
      FRAC_MICRO: frac_n = CNT_W'(7);
      FRAC_NANO:  frac_n = CNT_W'(10);
      default:    frac_n = '0;
    endcase
    case (s6_kind_q)
      OFF_ZULU: off_n = CNT_W'(1);
      OFF_FULL: off_n = CNT_W'(6);
      default:  off_n = '0;
    endcase
    s7_cnt_d = frac_n + off_n;

    // The offset text follows the fraction, wherever that ends.
    rel_idx = '0;
    for (int i = 0; i < MAX_CHARS_N; i++) begin
      rel_idx = CNT_W'(i) - frac_n;
      if (CNT_W'(i) < frac_n) begin
        s7_chars_d[i] = frac_chars[i];
      end else if (rel_idx < off_n) begin
        s7_chars_d[i] = off_chars[rel_idx[2:0]];
      end else begin
        s7_chars_d[i] = CH_NUL;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers; payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s1_ns_q   <= s1_ns_d;
      s1_mag_q  <= s1_mag_d;
      s1_neg_q  <= offset_seconds_i[OFFSET_W-1];
      s1_kind_q <= s1_kind_d;
    end
    if (stage_en[2]) begin
      s2_ns_q   <= s1_ns_q;
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_kind_q <= s1_kind_q;
      s2_p1_q   <= s2_p1_d;
      s2_hp_q   <= s2_hp_d;
    end
    if (stage_en[3]) begin
      s3_q1_q    <= s3_q1_d;
      s3_nn_q    <= s3_nn_d;
      s3_hours_q <= s3_hours_d;
      s3_rem_q   <= s3_rem_d;
      s3_neg_q   <= s2_neg_q;
      s3_kind_q  <= s2_kind_q;
    end
    if (stage_en[4]) begin
      s4_q1_q    <= s3_q1_q;
      s4_nn_q    <= s3_nn_q;
      s4_hours_q <= s3_hours_q;
      s4_neg_q   <= s3_neg_q;
      s4_kind_q  <= s3_kind_q;
      s4_msp_q   <= s4_msp_d;
      s4_minp_q  <= s4_minp_d;
    end
    if (stage_en[5]) begin
      s5_grp_q   <= s5_grp_d;
      s5_hours_q <= s4_hours_q;
      s5_min_q   <= s5_min_d;
      s5_neg_q   <= s4_neg_q;
      s5_kind_q  <= s4_kind_q;
      s5_frac_q  <= s5_frac_d;
    end
    if (stage_en[6]) begin
      s6_hund_q <= s6_hund_d;
      s6_r_q    <= s6_r_d;
      s6_ht_q   <= s6_ht_d;
      s6_hu_q   <= s6_hu_d;
      s6_mt_q   <= s6_mt_d;
      s6_mu_q   <= s6_mu_d;
      s6_neg_q  <= s5_neg_q;
      s6_kind_q <= s5_kind_q;
      s6_frac_q <= s5_frac_q;
    end
    if (stage_en[7]) begin
      s7_chars_q <= s7_chars_d;
      s7_cnt_q   <= s7_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output shift register: character zero is always the one on offer.
  always_comb begin
    buf_d       = buf_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (ser_load) begin
      buf_d       = s7_chars_q;
      rem_d       = s7_cnt_q;
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_CHARS_N - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[MAX_CHARS_N-1] = CH_NUL;
      rem_d       = rem_q - CNT_W'(1);
      out_valid_d = (rem_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = buf_q[0];
  assign last_char_o = (rem_q == CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Assertions.
  `TSFO_ASSERT_IMP(a_out_cnt, out_valid_q, (rem_q != '0) && (rem_q <= MAX_CHARS), "bad count")
  `TSFO_ASSERT_NXT(a_in_enters_pipe, in_valid_i && !in_stall_o, s_valid_q[1], "transaction lost")
  `TSFO_ASSERT_NXT(a_last_drains, out_acc && last_char_o && !ser_load, !out_valid_q, "no drain")
  `TSFO_ASSERT_IMP(a_s7_count_range, s_valid_q[NSTAGE], s7_cnt_q <= MAX_CHARS, "long item")

endmodule
